@@ hw/rtl/stc_pkg.sv @@
package stc_pkg;

    localparam int FUNC_W   = 2;
    localparam int TYPE_W   = 7;
    localparam int STATUS_W = 2;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FN_ADD_TYPE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ADD_SUPER = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY     = 2'd2;

    // Status codes returned with every response word.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CYCLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [TYPE_W-1:0]   type_idx_t;
    typedef logic [STATUS_W-1:0] status_t;

endpackage

@@ hw/rtl/stc_if.sv @@
interface stc_req_if
    import stc_pkg::*;
();
    logic      valid;
    logic      ready;
    func_t     func;
    type_idx_t first_type;
    type_idx_t second_type;

    modport source (output valid, output func, output first_type, output second_type,
                    input ready);
    modport sink   (input valid, input func, input first_type, input second_type,
                    output ready);
endinterface

interface stc_rsp_if
    import stc_pkg::*;
();
    logic      valid;
    logic      ready;
    status_t   status;
    logic      answer;
    type_idx_t new_index;

    modport source (output valid, output status, output answer, output new_index,
                    input ready);
    modport sink   (input valid, input status, input answer, input new_index,
                    output ready);
endinterface

@@ hw/rtl/stc_ram.sv @@
module stc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/subtype_closure_table_top.sv @@
// Subtype closure table: a reachability bit matrix over the registered types.
// Add type and every case settled from the indices alone go from the decode
// step straight to the finish step; a query that reads the matrix reads the
// first type's row; an add supertype that extends the closure reads both rows
// and walks over the stored rows through one read port of the row RAM.
// One request word is in work at a time. Reset clears the type count and the
// control state; rows are zeroed as types are added, so no clearing pass runs.
module subtype_closure_table_top
    import stc_pkg::*;
#(
    parameter int MAX_TYPES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    stc_req_if.sink   req,
    stc_rsp_if.source rsp
);

    // Row k-1 holds type k's proper supertypes, bit l-1 standing for type l.
    localparam int IDX_W = $clog2(MAX_TYPES);
    localparam int CNT_W = $clog2(MAX_TYPES + 1);
    localparam int W     = (CNT_W > TYPE_W) ? CNT_W : TYPE_W;

    typedef logic [MAX_TYPES-1:0] row_t;

    typedef enum logic [2:0] {
        IDLE,
        DECODE,
        ROW_A,
        ROW_B,
        WALK,
        FINISH
    } state_t;

    state_t           state_reg;
    func_t            func_reg;
    type_idx_t        a_reg;
    type_idx_t        b_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    row_t             mask_reg;

    // Result of the word in work, and the output register that holds it
    // until the sink takes it.
    status_t          res_status_reg;
    logic             res_answer_reg;
    type_idx_t        res_new_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic             out_answer_reg;
    type_idx_t        out_new_reg;

    // Outcome of the decode step, before any row is read.
    status_t          dec_status;
    logic             dec_answer;
    type_idx_t        dec_new;
    state_t           dec_state;

    // Row RAM ports.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    row_t             ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    row_t             ram_rdata;

    logic [W-1:0]     a_w;
    logic [W-1:0]     b_w;
    logic [W-1:0]     a_m1;
    logic [W-1:0]     b_m1;
    logic [W-1:0]     new_w;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic             a_ok;
    logic             b_ok;
    logic             full;
    logic             rbit_a;
    logic             rbit_b;
    logic             sub_a;
    logic             sub_b;
    logic             last_row;
    logic             same;
    logic             a_root;
    logic             b_root;

    assign req.ready     = (state_reg == IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.answer    = out_answer_reg;
    assign rsp.new_index = out_new_reg;

    // Index arithmetic. A valid nonzero index is at most type_count, so its
    // row number always fits the RAM address.
    assign a_w      = W'(a_reg);
    assign b_w      = W'(b_reg);
    assign a_m1     = a_w - W'(1);
    assign b_m1     = b_w - W'(1);
    assign a_idx    = a_m1[IDX_W-1:0];
    assign b_idx    = b_m1[IDX_W-1:0];
    assign a_ok     = a_w <= W'(count_reg);
    assign b_ok     = b_w <= W'(count_reg);
    assign new_w    = W'(count_reg) + W'(1);
    assign full     = count_reg == CNT_W'(MAX_TYPES);
    assign same     = a_reg == b_reg;
    assign a_root   = a_reg == '0;
    assign b_root   = b_reg == '0;
    assign rbit_a   = ram_rdata[a_idx];
    assign rbit_b   = ram_rdata[b_idx];

    // During the walk the RAM output is the row of type idx_reg + 1.
    assign sub_a    = (idx_reg == a_idx) || rbit_a;
    assign sub_b    = (idx_reg == b_idx) || rbit_b;
    assign last_row = (CNT_W'(idx_reg) + CNT_W'(1)) >= count_reg;

    // Everything that can be settled from the indices and the type count
    // alone; the remaining cases go on to read the matrix.
    always_comb
    begin
        dec_status = ST_OK;
        dec_answer = 1'b0;
        dec_new    = '0;
        dec_state  = FINISH;
        case (func_reg)
            FN_ADD_TYPE:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_new = new_w[TYPE_W-1:0];
                end
            end
            FN_ADD_SUPER:
            begin
                if (!(a_ok && b_ok))
                begin
                    dec_status = ST_RANGE;
                end
                else if (same || b_root)
                begin
                    dec_status = ST_OK;
                end
                else if (a_root)
                begin
                    // The root cannot take a proper supertype.
                    dec_status = ST_CYCLE;
                end
                else
                begin
                    dec_state = ROW_A;
                end
            end
            FN_QUERY:
            begin
                if (!(a_ok && b_ok))
                begin
                    dec_status = ST_RANGE;
                end
                else if (same || b_root)
                begin
                    dec_answer = 1'b1;
                end
                else if (!a_root)
                begin
                    dec_state = ROW_A;
                end
            end
            default:
            begin
                dec_status = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ram_rdata | mask_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            DECODE:
            begin
                if (func_reg == FN_ADD_TYPE)
                begin
                    // A new type starts with no proper supertype but the root.
                    ram_we    = !full;
                    ram_waddr = count_reg[IDX_W-1:0];
                    ram_wdata = '0;
                end
                else if ((func_reg == FN_ADD_SUPER || func_reg == FN_QUERY) &&
                         a_ok && b_ok && !same && !a_root && !b_root)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = a_idx;
                end
            end
            ROW_A:
            begin
                ram_re    = (func_reg == FN_ADD_SUPER) && !rbit_b;
                ram_raddr = b_idx;
            end
            ROW_B:
            begin
                // Start the walk at row 0, the row of type 1.
                ram_re    = !rbit_a;
                ram_raddr = '0;
            end
            WALK:
            begin
                // Write this row back while the next one is read; the two
                // addresses always differ, so no forwarding is needed.
                ram_we    = sub_a && !sub_b;
                ram_re    = !last_row;
                ram_raddr = idx_reg + IDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    stc_ram #(
        .WIDTH(MAX_TYPES),
        .DEPTH(MAX_TYPES)
    ) u_rows (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In FINISH the output register is reloaded whenever the word in
            // it is taken, so the valid bit is only dropped elsewhere.
            if (rsp.valid && rsp.ready && state_reg != FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (req.valid)
                    begin
                        func_reg  <= req.func;
                        a_reg     <= req.first_type;
                        b_reg     <= req.second_type;
                        state_reg <= DECODE;
                    end
                end

                DECODE:
                begin
                    res_status_reg <= dec_status;
                    res_answer_reg <= dec_answer;
                    res_new_reg    <= dec_new;
                    state_reg      <= dec_state;
                    if (func_reg == FN_ADD_TYPE && !full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end

                ROW_A:
                begin
                    if (func_reg == FN_QUERY)
                    begin
                        res_answer_reg <= rbit_b;
                        state_reg      <= FINISH;
                    end
                    else if (rbit_b)
                    begin
                        // The relation already holds.
                        state_reg <= FINISH;
                    end
                    else
                    begin
                        state_reg <= ROW_B;
                    end
                end

                ROW_B:
                begin
                    if (rbit_a)
                    begin
                        res_status_reg <= ST_CYCLE;
                        state_reg      <= FINISH;
                    end
                    else
                    begin
                        // Every affected row gains the second type and all of
                        // its supertypes.
                        mask_reg  <= ram_rdata | (row_t'(1) << b_idx);
                        idx_reg   <= '0;
                        state_reg <= WALK;
                    end
                end

                WALK:
                begin
                    if (last_row)
                    begin
                        state_reg <= FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end

                FINISH:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_answer_reg <= res_answer_reg;
                        out_new_reg    <= res_new_reg;
                        state_reg      <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/stc_checker.sv @@
module stc_checker
    import stc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input status_t   rsp_status,
    input logic      rsp_answer,
    input type_idx_t rsp_new_index
);

    // A stalled response word holds its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_answer) && $stable(rsp_new_index))
        else $error("response word changed while stalled");

    // Only one request word is in work: the block is busy right after taking one.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    // A true answer comes only with an ok status.
    a_answer_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_answer |-> rsp_status == ST_OK)
        else $error("answer set on an error status");

    // A new index is reported only by a successful add type.
    a_index_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_new_index != '0 |-> rsp_status == ST_OK && !rsp_answer)
        else $error("new index with error status or answer");

    // A full table reports no index and no answer.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_new_index == '0 && !rsp_answer)
        else $error("full status with index or answer");

endmodule

bind subtype_closure_table_top stc_checker u_stc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_answer   (rsp.answer),
    .rsp_new_index(rsp.new_index)
);

@@ tb/sv/subtype_closure_table_top_tb.sv @@
`timescale 1ns / 100ps

module subtype_closure_table_top_tb;

    import stc_pkg::*;

    localparam int MAX_T = 64;

    // The func field has one code that the block does not define.
    localparam func_t FN_UNUSED = 2'd3;

    // Each request is worked on alone. The slowest case walks every stored row,
    // so this many quiet cycles at the end cover any late stray word.
    localparam int DRAIN_CYCLES = MAX_T + 40;

    typedef struct packed {
        func_t     func;
        type_idx_t first_type;
        type_idx_t second_type;
    } request_t;

    typedef struct packed {
        status_t   status;
        logic      answer;
        type_idx_t new_index;
    } reply_t;

    logic clk;
    logic rst_n;

    stc_req_if req_ch ();
    stc_rsp_if rsp_ch ();

    subtype_closure_table_top #(
        .MAX_TYPES (MAX_T)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Request words that still have to be offered, and the response words
    // that the accepted requests are owed, oldest first.
    request_t request_backlog [$];
    reply_t   predicted_replies [$];

    // The testbench's own copy of the closure matrix. Row k-1 holds one bit
    // per type l at bit l-1, set when type k lies strictly below type l.
    logic [MAX_T-1:0] reach [MAX_T];
    int               type_total;

    // Type count as seen by the stimulus generator, so that random operands
    // can be kept inside or pushed outside the registered range on purpose.
    int gen_total;

    int  taken_count;
    int  mismatch_count;
    logic req_fire;

    always #1 clk = ~clk;

    // A type index names something only if it is the root or was registered.
    function automatic logic is_known(int t);
        return t <= type_total;
    endfunction

    // Subtype test on two known indices. The root sits above everything and
    // below nothing but itself.
    function automatic logic is_below(int a, int b);
        if (a == b)
            return 1'b1;
        if (a == 0)
            return 1'b0;
        if (b == 0)
            return 1'b1;
        return reach[a-1][b-1];
    endfunction

    // Applies one request to the matrix copy and returns the word the block
    // must send back for it.
    function automatic reply_t apply_request(func_t fn, type_idx_t a_in, type_idx_t b_in);
        reply_t           r;
        int               a;
        int               b;
        int               k;
        logic [MAX_T-1:0] mask;
        r.status    = ST_OK;
        r.answer    = 1'b0;
        r.new_index = '0;
        a = a_in;
        b = b_in;
        case (fn)
            FN_ADD_TYPE:
            begin
                if (type_total >= MAX_T)
                    r.status = ST_FULL;
                else
                begin
                    type_total++;
                    reach[type_total-1] = '0;
                    r.new_index = type_idx_t'(type_total);
                end
            end
            FN_ADD_SUPER:
            begin
                if (!is_known(a) || !is_known(b))
                    r.status = ST_RANGE;
                else if (is_below(a, b))
                    r.status = ST_OK;
                else if (is_below(b, a))
                    r.status = ST_CYCLE;
                else
                begin
                    // Everything at or below a that is not yet below b picks
                    // up b together with all of b's supertypes.
                    mask = reach[b-1];
                    mask[b-1] = 1'b1;
                    for (k = 1; k <= type_total; k++)
                    begin
                        if (is_below(k, a) && !is_below(k, b))
                            reach[k-1] = reach[k-1] | mask;
                    end
                end
            end
            FN_QUERY:
            begin
                if (!is_known(a) || !is_known(b))
                    r.status = ST_RANGE;
                else
                    r.answer = is_below(a, b);
            end
            default:
                r.status = ST_RANGE;
        endcase
        return r;
    endfunction

    task automatic queue_request(func_t fn, int a, int b);
        request_t q;
        q.func        = fn;
        q.first_type  = type_idx_t'(a);
        q.second_type = type_idx_t'(b);
        request_backlog = {request_backlog, q};
        if (fn == FN_ADD_TYPE && gen_total < MAX_T)
            gen_total++;
    endtask

    // Picks a registered index, mostly a real type rather than the root.
    function automatic int pick_known();
        if (gen_total > 0 && $urandom_range(0, 9) != 0)
            return $urandom_range(1, gen_total);
        return 0;
    endfunction

    // Both sides run without gaps for a stretch in the middle of the run.
    function automatic logic calm_stretch();
        return taken_count >= 300 && taken_count < 500;
    endfunction

    // Sampling side. Accepted requests are predicted at the edge where they
    // are taken; response words are checked against the oldest prediction.
    // Requests go first so that even a reply in the same cycle finds its entry.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                want = apply_request(req_ch.func, req_ch.first_type, req_ch.second_type);
                predicted_replies = {predicted_replies, want};
                taken_count <= taken_count + 1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("response word with no request waiting for it");
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatch_count++;
                    end
                    if (rsp_ch.answer !== want.answer)
                    begin
                        $error("answer: expected %0d, got %0d", want.answer, rsp_ch.answer);
                        mismatch_count++;
                    end
                    if (rsp_ch.new_index !== want.new_index)
                    begin
                        $error("new_index: expected %0d, got %0d", want.new_index,
                               rsp_ch.new_index);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Request driver. A new word is put up only once the previous one was
    // taken (or none was up); about one cycle in twelve is left empty.
    always @(negedge clk)
    begin
        request_t nxt;
        if (rst_n)
        begin
            if (!req_ch.valid || req_fire)
            begin
                if (request_backlog.size() > 0 &&
                    (calm_stretch() || $urandom_range(0, 99) >= 8))
                begin
                    nxt = request_backlog.pop_front();
                    req_ch.func        <= nxt.func;
                    req_ch.first_type  <= nxt.first_type;
                    req_ch.second_type <= nxt.second_type;
                    req_ch.valid       <= 1'b1;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response back-pressure, with the same rate and the same calm stretch.
    always @(negedge clk)
    begin
        if (rst_n)
            rsp_ch.ready <= calm_stretch() || $urandom_range(0, 99) >= 8;
    end

    initial
    begin
        int i;
        int pick;
        clk = 1'b0;
        rst_n = 1'b0;
        req_fire = 1'b0;
        taken_count = 0;
        mismatch_count = 0;
        type_total = 0;
        gen_total = 0;
        for (i = 0; i < MAX_T; i++)
            reach[i] = '0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FN_ADD_TYPE;
        req_ch.first_type  = '0;
        req_ch.second_type = '0;
        rsp_ch.ready       = 1'b0;

        // Directed opening: an empty table, a small chain of three types,
        // the shortcut cases, cycles and the out-of-range paths.
        queue_request(FN_QUERY, 0, 0);          // root is a subtype of itself
        queue_request(FN_QUERY, 1, 0);          // nothing registered yet
        queue_request(FN_ADD_SUPER, 0, 0);      // equal types, no change
        queue_request(FN_UNUSED, 127, 127);
        queue_request(FN_ADD_TYPE, 127, 127);
        queue_request(FN_ADD_TYPE, 0, 0);
        queue_request(FN_ADD_TYPE, 64, 64);
        queue_request(FN_ADD_SUPER, 1, 2);
        queue_request(FN_ADD_SUPER, 2, 3);      // 1 must inherit 3 as well
        queue_request(FN_QUERY, 1, 3);
        queue_request(FN_ADD_SUPER, 3, 1);      // would close a loop
        queue_request(FN_ADD_SUPER, 1, 3);      // already holds
        queue_request(FN_ADD_SUPER, 1, 0);      // root as supertype always holds
        queue_request(FN_ADD_SUPER, 0, 1);      // root under a type is a loop
        queue_request(FN_QUERY, 0, 1);
        queue_request(FN_QUERY, 2, 1);
        queue_request(FN_ADD_SUPER, 2, 2);
        queue_request(FN_QUERY, 3, 3);
        queue_request(FN_ADD_SUPER, 4, 1);      // one past the last type
        queue_request(FN_ADD_SUPER, 1, 127);
        queue_request(FN_QUERY, 127, 0);
        queue_request(FN_QUERY, 0, 64);
        queue_request(FN_UNUSED, 0, 0);

        // Random part. Most words are well-formed relation building and
        // queries among registered types; add type comes often enough that
        // the table fills up partway through and the full case gets hit.
        for (i = 0; i < 1030; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                queue_request(FN_ADD_TYPE, $urandom_range(0, 127), $urandom_range(0, 127));
            else if (pick < 52)
                queue_request(FN_ADD_SUPER, pick_known(), pick_known());
            else if (pick < 88)
                queue_request(FN_QUERY, pick_known(), pick_known());
            else if (pick < 96)
            begin
                // One operand beyond the registered range, on either side.
                if ($urandom_range(0, 1) == 0)
                    queue_request($urandom_range(0, 1) ? FN_QUERY : FN_ADD_SUPER,
                                  $urandom_range(gen_total + 1, 127), pick_known());
                else
                    queue_request($urandom_range(0, 1) ? FN_QUERY : FN_ADD_SUPER,
                                  pick_known(), $urandom_range(gen_total + 1, 127));
            end
            else
                queue_request(FN_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every reply to come back,
        // then leave the block alone long enough to expose a stray word.
        while (request_backlog.size() > 0 || req_ch.valid)
            @(posedge clk);
        while (predicted_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("subtype_closure_table_top_tb: clean");
        else
            $display("subtype_closure_table_top_tb: errors");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial
    begin
        #2000000;
        $display("subtype_closure_table_top_tb: errors");
        $finish;
    end

endmodule
